[rtl/pps_pkg.sv]
// shared types and constants of the preemptive priority scheduler
package pps_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TIME_W    = 24;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_SUB_TAT,
        S_SUB_WT,
        S_SUB_RT,
        S_OUT
    } t_state;

endpackage

[rtl/preemptive_priority_scheduler_top.sv]
// tick-driven preemptive priority scheduler with a sequential slot scan
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_stall    i_opcode i_slot i_arrival i_burst i_prio
//  result   out        o_valid / i_stall    o_ran o_task_id o_now_after o_finished
//                                           o_completion o_turnaround o_waiting
//                                           o_response o_all_done
//
// a tick result passes through the scan, one slot per scan cycle, then an update step, three
// steps on the shared subtractor when the task finishes, and the output load; the next item
// is accepted in idle after the output load
// clear, load and unused opcodes go from accept straight to the output load
// o_stall is high whenever an item is in progress; a result held by i_stall blocks the
// final step of the next item, and no further item is accepted while it waits
// i_rst_n is synchronous and empties the table and sets time to zero
module preemptive_priority_scheduler_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_opcode,
    input  logic [3:0]           i_slot,
    input  logic [15:0]          i_arrival,
    input  logic [15:0]          i_burst,
    input  logic [7:0]           i_prio,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_ran,
    output logic [4:0]           o_task_id,
    output logic [23:0]          o_now_after,
    output logic                 o_finished,
    output logic [23:0]          o_completion,
    output logic [23:0]          o_turnaround,
    output logic [23:0]          o_waiting,
    output logic [23:0]          o_response,
    output logic                 o_all_done
);
    import pps_pkg::*;

    localparam t_idx LAST_IDX = t_idx'(MAX_TASKS - 1);

    t_state r_state, n_state;

    // slot table
    logic         r_valid     [MAX_TASKS];
    logic [15:0]  r_remaining [MAX_TASKS];
    logic         r_started   [MAX_TASKS];
    logic [15:0]  r_arrival   [MAX_TASKS];
    logic [15:0]  r_burst     [MAX_TASKS];
    logic [7:0]   r_prio      [MAX_TASKS];
    t_time        r_first     [MAX_TASKS];

    t_time        r_now;
    t_idx         r_idx;

    // best candidate found so far
    logic         r_found;
    t_idx         r_best;
    logic [7:0]   r_best_prio;
    logic [15:0]  r_best_arr;
    logic [15:0]  r_best_burst;
    logic [15:0]  r_best_rem;
    logic         r_best_started;
    t_time        r_best_fs;

    logic         r_ran;
    logic         r_fin;
    t_time        r_tat;
    t_time        r_wt;
    t_time        r_rt;

    logic         r_o_valid;
    logic         r_o_ran;
    logic [4:0]   r_o_task_id;
    t_time        r_o_now;
    logic         r_o_fin;
    t_time        r_o_completion;
    t_time        r_o_tat;
    t_time        r_o_wt;
    t_time        r_o_rt;
    logic         r_o_all_done;

    logic         in_accept;
    logic         load_en;
    t_idx         load_idx;
    logic         cand;
    logic         busy_any;
    logic         out_free;
    t_time        sub_a;
    t_time        sub_b;
    t_time        sub_y;

    assign in_accept = i_valid && !o_stall;
    assign load_idx  = t_idx'(i_slot);
    assign load_en   = in_accept && (t_opcode'(i_opcode) == OP_LOAD)
                       && (int'(i_slot) < MAX_TASKS);
    assign out_free  = !r_o_valid || !i_stall;

    // compare unit for the scan
    assign cand = r_valid[r_idx] && ({8'd0, r_arrival[r_idx]} <= r_now)
                  && (r_remaining[r_idx] != 16'd0)
                  && (!r_found || (r_prio[r_idx] < r_best_prio));

    always_comb begin
        busy_any = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            busy_any = busy_any | (r_valid[i] && (r_remaining[i] != 16'd0));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (t_opcode'(i_opcode) == OP_TICK) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_found && (r_best_rem == 16'd1)) begin
                    n_state = S_SUB_TAT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SUB_TAT: n_state = S_SUB_WT;
            S_SUB_WT:  n_state = S_SUB_RT;
            S_SUB_RT:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer: input stall and shared subtractor operands
    always_comb begin
        o_stall = 1'b1;
        sub_a   = r_now;
        sub_b   = {8'd0, r_best_arr};
        unique case (r_state)
            S_IDLE:    o_stall = 1'b0;
            S_SUB_TAT: begin
                sub_a = r_now;
                sub_b = {8'd0, r_best_arr};
            end
            S_SUB_WT: begin
                sub_a = r_tat;
                sub_b = {8'd0, r_best_burst};
            end
            S_SUB_RT: begin
                sub_a = r_best_fs;
                sub_b = {8'd0, r_best_arr};
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign sub_y = sub_a - sub_b;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_now     <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_ran     <= 1'b0;
            r_fin     <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_valid[i]     <= 1'b0;
                r_remaining[i] <= '0;
                r_started[i]   <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (in_accept) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_ran   <= 1'b0;
                r_fin   <= 1'b0;
                if (t_opcode'(i_opcode) == OP_CLEAR) begin
                    r_now <= '0;
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        r_valid[i]     <= 1'b0;
                        r_remaining[i] <= '0;
                        r_started[i]   <= 1'b0;
                    end
                end
            end
            if (load_en) begin
                r_valid[load_idx]     <= 1'b1;
                r_remaining[load_idx] <= i_burst;
                r_started[load_idx]   <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                if (cand) begin
                    r_found <= 1'b1;
                end
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + t_idx'(1);
            end
            if (r_state == S_UPDATE) begin
                r_now <= r_now + t_time'(1);
                r_ran <= r_found;
                r_fin <= r_found && (r_best_rem == 16'd1);
                if (r_found) begin
                    r_remaining[r_best] <= r_best_rem - 16'd1;
                    r_started[r_best]   <= 1'b1;
                end
            end
        end
    end

    // datapath and payload
    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_arrival[load_idx] <= i_arrival;
            r_burst[load_idx]   <= i_burst;
            r_prio[load_idx]    <= i_prio;
        end
        if ((r_state == S_SCAN) && cand) begin
            r_best         <= r_idx;
            r_best_prio    <= r_prio[r_idx];
            r_best_arr     <= r_arrival[r_idx];
            r_best_burst   <= r_burst[r_idx];
            r_best_rem     <= r_remaining[r_idx];
            r_best_started <= r_started[r_idx];
            r_best_fs      <= r_first[r_idx];
        end
        if ((r_state == S_UPDATE) && r_found && !r_best_started) begin
            // first run of this task: start time is the time before the tick
            r_first[r_best] <= r_now;
            r_best_fs       <= r_now;
        end
        if (r_state == S_SUB_TAT) begin
            r_tat <= sub_y;
        end
        if (r_state == S_SUB_WT) begin
            r_wt <= sub_y;
        end
        if (r_state == S_SUB_RT) begin
            r_rt <= sub_y;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_o_ran        <= r_ran;
            r_o_task_id    <= r_ran ? (5'(r_best) + 5'd1) : 5'd0;
            r_o_now        <= r_now;
            r_o_fin        <= r_fin;
            r_o_completion <= r_fin ? r_now : '0;
            r_o_tat        <= r_fin ? r_tat : '0;
            r_o_wt         <= r_fin ? r_wt : '0;
            r_o_rt         <= r_fin ? r_rt : '0;
            r_o_all_done   <= !busy_any;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_ran        = r_o_ran;
    assign o_task_id    = r_o_task_id;
    assign o_now_after  = r_o_now;
    assign o_finished   = r_o_fin;
    assign o_completion = r_o_completion;
    assign o_turnaround = r_o_tat;
    assign o_waiting    = r_o_wt;
    assign o_response   = r_o_rt;
    assign o_all_done   = r_o_all_done;

    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> o_ran)
        else $error("finished result without a task that ran");

    a_id_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ran == (o_task_id != 5'd0)))
        else $error("task id does not agree with ran flag");

    a_completion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> (o_completion == o_now_after))
        else $error("completion time differs from time after tick");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_idx == '0))
        else $error("scan index not at first slot while idle");

    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> (r_now == $past(r_now) + t_time'(1)))
        else $error("tick did not advance time by one");

endmodule

[verif/tb_top.sv]
// self-checking testbench of the preemptive priority scheduler
`timescale 1ns / 100ps

import pps_pkg::*;

typedef struct packed {
    logic        ran;
    logic [4:0]  task_id;
    t_time       now_after;
    logic        finished;
    t_time       completion;
    t_time       turnaround;
    t_time       waiting;
    t_time       response;
    logic        all_done;
} t_sched_result;

class sched_tracker;
    bit            slot_used  [MAX_TASKS];
    logic [15:0]   slot_arr   [MAX_TASKS];
    logic [15:0]   slot_len   [MAX_TASKS];
    logic [7:0]    slot_pri   [MAX_TASKS];
    logic [15:0]   slot_left  [MAX_TASKS];
    bit            slot_begun [MAX_TASKS];
    t_time         slot_start [MAX_TASKS];
    t_time         clock_now;
    t_sched_result pending_results[$];
    int            mismatches;
    int            items_taken;

    function new();
        wipe_table();
        mismatches  = 0;
        items_taken = 0;
    endfunction

    function void wipe_table();
        int i;
        for (i = 0; i < MAX_TASKS; i++) begin
            slot_used[i]  = 1'b0;
            slot_arr[i]   = '0;
            slot_len[i]   = '0;
            slot_pri[i]   = '0;
            slot_left[i]  = '0;
            slot_begun[i] = 1'b0;
            slot_start[i] = '0;
        end
        clock_now = '0;
    endfunction

    // predicts the result of one accepted item and queues it
    function void accept_item(t_opcode op, logic [3:0] slot, logic [15:0] arr,
                              logic [15:0] len, logic [7:0] pri);
        t_sched_result r;
        int            pick;
        int            i;
        r    = '0;
        pick = -1;
        items_taken++;
        case (op)
            OP_CLEAR: wipe_table();
            OP_LOAD: begin
                if (int'(slot) < MAX_TASKS) begin
                    slot_used[slot]  = 1'b1;
                    slot_arr[slot]   = arr;
                    slot_len[slot]   = len;
                    slot_pri[slot]   = pri;
                    slot_left[slot]  = len;
                    slot_begun[slot] = 1'b0;
                    slot_start[slot] = '0;
                end
            end
            OP_TICK: begin
                for (i = 0; i < MAX_TASKS; i++) begin
                    if (slot_used[i] && t_time'(slot_arr[i]) <= clock_now
                            && slot_left[i] != 0) begin
                        if (pick < 0 || slot_pri[i] < slot_pri[pick])
                            pick = i;
                    end
                end
                if (pick >= 0) begin
                    if (!slot_begun[pick]) begin
                        slot_begun[pick] = 1'b1;
                        slot_start[pick] = clock_now;
                    end
                    slot_left[pick] = slot_left[pick] - 16'd1;
                    r.ran     = 1'b1;
                    r.task_id = 5'(pick + 1);
                end
                clock_now = clock_now + t_time'(1);
                if (pick >= 0 && slot_left[pick] == 0) begin
                    r.finished   = 1'b1;
                    r.completion = clock_now;
                    r.turnaround = clock_now - t_time'(slot_arr[pick]);
                    r.waiting    = r.turnaround - t_time'(slot_len[pick]);
                    r.response   = slot_start[pick] - t_time'(slot_arr[pick]);
                end
            end
            default: ;
        endcase
        r.now_after = clock_now;
        r.all_done  = 1'b1;
        for (i = 0; i < MAX_TASKS; i++)
            if (slot_used[i] && slot_left[i] != 0)
                r.all_done = 1'b0;
        pending_results.push_back(r);
    endfunction

    function void flag(string what, logic [23:0] want, logic [23:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d", what, want, got);
    endfunction

    function void check_result(t_sched_result got);
        t_sched_result want;
        if (pending_results.size() == 0) begin
            flag("result with nothing expected", '0, '0);
            return;
        end
        want = pending_results.pop_front();
        if (got.ran !== want.ran)               flag("ran", 24'(want.ran), 24'(got.ran));
        if (got.task_id !== want.task_id)       flag("task_id", 24'(want.task_id), 24'(got.task_id));
        if (got.now_after !== want.now_after)   flag("now_after", want.now_after, got.now_after);
        if (got.finished !== want.finished)
            flag("finished", 24'(want.finished), 24'(got.finished));
        if (got.completion !== want.completion) flag("completion", want.completion, got.completion);
        if (got.turnaround !== want.turnaround) flag("turnaround", want.turnaround, got.turnaround);
        if (got.waiting !== want.waiting)       flag("waiting", want.waiting, got.waiting);
        if (got.response !== want.response)     flag("response", want.response, got.response);
        if (got.all_done !== want.all_done)
            flag("all_done", 24'(want.all_done), 24'(got.all_done));
    endfunction
endclass

module tb_top;

    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_AT      = 3000;
    localparam int HOLD_LEN     = 600;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [1:0]  i_opcode  = OP_NONE;
    logic [3:0]  i_slot    = '0;
    logic [15:0] i_arrival = '0;
    logic [15:0] i_burst   = '0;
    logic [7:0]  i_prio    = '0;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_ran;
    logic [4:0]  o_task_id;
    logic [23:0] o_now_after;
    logic        o_finished;
    logic [23:0] o_completion;
    logic [23:0] o_turnaround;
    logic [23:0] o_waiting;
    logic [23:0] o_response;
    logic        o_all_done;

    sched_tracker tracker = new();

    int send_idle_pct = 18;
    int recv_idle_pct = 74;
    int cycle_cnt     = 0;
    int hold_left     = 0;

    preemptive_priority_scheduler_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_slot       (i_slot),
        .i_arrival    (i_arrival),
        .i_burst      (i_burst),
        .i_prio       (i_prio),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ran        (o_ran),
        .o_task_id    (o_task_id),
        .o_now_after  (o_now_after),
        .o_finished   (o_finished),
        .o_completion (o_completion),
        .o_turnaround (o_turnaround),
        .o_waiting    (o_waiting),
        .o_response   (o_response),
        .o_all_done   (o_all_done)
    );

    always #10 i_clk = ~i_clk;

    // result side: random stall, one long hold-off, check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_result({o_ran, o_task_id, o_now_after, o_finished, o_completion,
                                  o_turnaround, o_waiting, o_response, o_all_done});
        cycle_cnt++;
        if (hold_left > 0)
            hold_left--;
        else if (cycle_cnt == HOLD_AT)
            hold_left = HOLD_LEN;
        i_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_item(t_opcode op, logic [3:0] slot, logic [15:0] arr,
                             logic [15:0] len, logic [7:0] pri);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_slot    <= slot;
        i_arrival <= arr;
        i_burst   <= len;
        i_prio    <= pri;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        tracker.accept_item(op, slot, arr, len, pri);
        // idle mix: sender light / receiver heavy, then swapped, then none
        if (tracker.items_taken < RANDOM_ITEMS / 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 74;
        end else if (tracker.items_taken < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 74;
            recv_idle_pct = 18;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic send_noise();
        send_item(t_opcode'($urandom_range(3)), 4'($urandom_range(15)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  8'($urandom_range(255)));
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 8'($urandom_range(255)));
    endtask

    task automatic send_small_load(inout int busy_until);
        logic [15:0] arr;
        logic [15:0] len;
        arr = 16'($urandom_range(12));
        len = 16'($urandom_range(1, 6));
        send_item(OP_LOAD, 4'($urandom_range(15)), arr, len, 8'($urandom_range(7)));
        busy_until += int'(arr) + int'(len);
    endtask

    // one job set: optional clear, a few tasks with small times, then mostly ticks (at most 60 items)
    task automatic run_job_set();
        int busy_until;
        int n_ticks;
        int n_loads;
        int k;
        int roll;
        busy_until = 2;
        if ($urandom_range(99) < 80)
            send_item(OP_CLEAR, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                      16'($urandom_range(65535)), 8'($urandom_range(255)));
        n_loads = $urandom_range(1, 6);
        for (k = 0; k < n_loads; k++)
            send_small_load(busy_until);
        n_ticks = (busy_until > 60) ? 60 : busy_until;
        for (k = 0; k < n_ticks; k++) begin
            roll = $urandom_range(99);
            if (roll < 2)
                send_noise();
            else if (roll < 5)
                send_item(OP_NONE, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)), 8'($urandom_range(255)));
            else if (roll < 10)
                send_small_load(busy_until);
            else
                send_tick();
        end
    endtask

    initial begin
        int drain_wait;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, unused opcode, zero burst, field extremes
        send_tick();
        send_item(OP_NONE, 4'd0, 16'd0, 16'd0, 8'd0);
        send_item(OP_LOAD, 4'd0, 16'd0, 16'd0, 8'd0);
        send_tick();
        send_item(OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);
        // equal priority picks the lower slot, an urgent task that has arrived runs first
        send_item(OP_LOAD, 4'd3, 16'd0, 16'd2, 8'd5);
        send_item(OP_LOAD, 4'd1, 16'd0, 16'd1, 8'd5);
        send_item(OP_LOAD, 4'd2, 16'd2, 16'd1, 8'd0);
        repeat (4) send_tick();
        // reloading a finished slot restarts it
        send_item(OP_LOAD, 4'd3, 16'd0, 16'd1, 8'd0);
        send_tick();
        send_tick();
        send_item(OP_NONE, 4'd5, 16'h1234, 16'h4321, 8'h77);
        send_item(OP_CLEAR, 4'd0, 16'd0, 16'd0, 8'd0);
        send_item(OP_LOAD, 4'd10, 16'hAAAA, 16'h5555, 8'hAA);
        send_item(OP_LOAD, 4'd5, 16'h5555, 16'hAAAA, 8'h55);
        send_tick();
        send_item(OP_CLEAR, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);

        while (tracker.items_taken < RANDOM_ITEMS)
            run_job_set();

        i_valid <= 1'b0;
        drain_wait = 0;
        while (tracker.pending_results.size() != 0 && drain_wait < 100000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
